// ===== design/evfil_pkg.sv =====
// Package for the equal-value first-index linker.
// Holds table sizes, widths, the controller state type and the command and status structs; no dependencies.
package evfil_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned SlotBits     = $clog2(TableEntries);
  localparam int unsigned IndexBits    = 16;
  localparam int unsigned ValueBits    = 64;

  localparam logic [IndexBits-1:0] IndexMax = {IndexBits{1'b1}};
  localparam logic [10:0]          ExpOnes  = 11'h7FF;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;     // capture input, clear scan
    logic step;      // issue one table read and compare the previous one
    logic finish;    // commit and present result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_end;  // last entry compared or early stop
  } dp_status_t;

endpackage

// ===== design/equal_value_first_index_linker_core.sv =====
// Top level of the equal-value first-index linker.
// Depends on evfil_pkg, evfil_ctrl and evfil_datapath.
//
// Usage: drive value_bits_i and start_of_set_i with start high; the node is
// taken at a rising edge where start is high and busy is low. Setting
// start_of_set_i clears the value table and both counters first.
// The controller then walks the 64-entry table one entry a cycle through a
// registered read and a single comparator, each compare in the cycle after its
// read, stopping at the first match; non-finite values and a saturated node
// index skip the walk. The done state then updates the table and registers
// the result.
// The next transaction can be taken at the edge that ends the result strobe;
// no new node is taken while a scan is in progress, so throughput is set by
// the table scan.
// Results: node_index_o, linked_o, link_target_o, links_so_far_o and
// overflow_o are valid for the single cycle in which valid_o is high; the
// receiver cannot stall and must take them then.
// Reset: rst_ni low clears the table valid bits, both counters and the
// controller; the block is ready as soon as reset is released.
module equal_value_first_index_linker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_bits_i,
  input  logic        start_of_set_i,
  output logic        valid_o,
  output logic [15:0] node_index_o,
  output logic        linked_o,
  output logic [15:0] link_target_o,
  output logic [15:0] links_so_far_o,
  output logic        overflow_o
);
  import evfil_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  evfil_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .done_o   (valid_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  evfil_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_bits_i   (value_bits_i),
    .start_of_set_i (start_of_set_i),
    .node_index_o   (node_index_o),
    .linked_o       (linked_o),
    .link_target_o  (link_target_o),
    .links_so_far_o (links_so_far_o),
    .overflow_o     (overflow_o)
  );

endmodule

// ===== design/evfil_datapath.sv =====
// Datapath of the linker: value table, counters and one-entry-per-cycle compare.
// Depends on evfil_pkg.
module evfil_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  evfil_pkg::dp_cmd_t                 cmd_i,
  output evfil_pkg::dp_status_t              status_o,
  input  logic [evfil_pkg::ValueBits-1:0]    value_bits_i,
  input  logic                               start_of_set_i,
  output logic [15:0]                        node_index_o,
  output logic                               linked_o,
  output logic [15:0]                        link_target_o,
  output logic [15:0]                        links_so_far_o,
  output logic                               overflow_o
);
  import evfil_pkg::*;

  logic [ValueBits-1:0] mem_value [TableEntries];
  logic [IndexBits-1:0] mem_first [TableEntries];
  logic [TableEntries-1:0] valid_q, valid_d;

  logic [ValueBits-1:0] val_q;
  logic                 finite_q;
  logic [IndexBits-1:0] node_cnt_q, node_cnt_d;
  logic [IndexBits-1:0] link_cnt_q, link_cnt_d;
  logic [IndexBits-1:0] me_q;
  logic [SlotBits-1:0]  slot_q;
  logic [SlotBits-1:0]  cmp_slot_q;
  logic                 cmp_vld_q;
  logic                 hit_q, free_found_q;
  logic [SlotBits-1:0]  free_slot_q;
  logic [IndexBits-1:0] target_q;
  logic                 sat_q;
  logic [ValueBits-1:0] rd_value_q;
  logic [IndexBits-1:0] rd_first_q;

  logic [ValueBits-1:0] fold_val;
  logic                 eq_hit;
  logic                 free_seen;
  logic                 last_cmp;
  logic                 commit_link;
  logic                 commit_store;
  logic                 ovf;

  // Fold -0 to +0
  assign fold_val = (value_bits_i[ValueBits-2:0] == '0) ? '0 : value_bits_i;

  // Counter values seen by a new transaction
  assign node_cnt_d = start_of_set_i ? '0 : node_cnt_q;
  assign link_cnt_d = start_of_set_i ? '0 : link_cnt_q;
  assign valid_d    = start_of_set_i ? '0 : valid_q;

  // Compare the entry held in the read register, in the cycle after its read
  assign eq_hit    = cmp_vld_q && valid_q[cmp_slot_q] && (rd_value_q == val_q);
  assign free_seen = cmp_vld_q && !valid_q[cmp_slot_q];
  assign last_cmp  = cmp_vld_q && (cmp_slot_q == SlotBits'(TableEntries - 1));

  assign status_o.scan_end = last_cmp || eq_hit || !finite_q || sat_q;

  assign commit_link  = finite_q && !sat_q && hit_q;
  assign commit_store = finite_q && !sat_q && !hit_q && free_found_q;

  // Control registers: counters, valid bits, scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      node_cnt_q   <= '0;
      link_cnt_q   <= '0;
      me_q         <= '0;
      slot_q       <= '0;
      cmp_slot_q   <= '0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      finite_q     <= 1'b0;
      sat_q        <= 1'b0;
    end else if (cmd_i.latch) begin
      valid_q      <= valid_d;
      link_cnt_q   <= link_cnt_d;
      me_q         <= node_cnt_d;
      sat_q        <= (node_cnt_d >= IndexMax);
      node_cnt_q   <= (node_cnt_d >= IndexMax) ? node_cnt_d : node_cnt_d + 1'b1;
      finite_q     <= (value_bits_i[62:52] != ExpOnes);
      slot_q       <= '0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (eq_hit) begin
        hit_q <= 1'b1;
      end
      if (free_seen && !free_found_q) begin
        free_found_q <= 1'b1;
      end
      cmp_vld_q  <= 1'b1;
      cmp_slot_q <= slot_q;
      if (slot_q != SlotBits'(TableEntries - 1)) begin
        slot_q <= slot_q + 1'b1;
      end
    end else if (cmd_i.finish) begin
      if (commit_link) begin
        if (link_cnt_q < IndexMax) begin
          link_cnt_q <= link_cnt_q + 1'b1;
        end
      end else if (commit_store) begin
        valid_q[free_slot_q] <= 1'b1;
      end
    end
  end

  // Payload registers of the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      val_q <= fold_val;
    end else if (cmd_i.step) begin
      if (eq_hit) begin
        target_q <= rd_first_q;
      end
      if (free_seen && !free_found_q) begin
        free_slot_q <= cmp_slot_q;
      end
    end
  end

  // Table: registered read under the scan pointer, write on a new distinct value
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      rd_value_q <= mem_value[slot_q];
      rd_first_q <= mem_first[slot_q];
    end
    if (cmd_i.finish && commit_store) begin
      mem_value[free_slot_q] <= val_q;
      mem_first[free_slot_q] <= me_q;
    end
  end

  assign ovf = sat_q || (finite_q && !hit_q && !free_found_q);

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      node_index_o   <= me_q[15:0];
      linked_o       <= commit_link;
      link_target_o  <= commit_link ? target_q[15:0] : '0;
      links_so_far_o <= (commit_link && link_cnt_q < IndexMax)
                        ? link_cnt_q + 1'b1 : link_cnt_q;
      overflow_o     <= ovf;
    end
  end

endmodule

// ===== design/evfil_ctrl.sv =====
// Controller of the linker: sequences latch, scan and commit of one transaction.
// Depends on evfil_pkg.
module evfil_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  output logic                  done_o,
  output evfil_pkg::dp_cmd_t    cmd_o,
  input  evfil_pkg::dp_status_t status_i
);
  import evfil_pkg::*;

  ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (start_i) state_d = StScan;
      StScan: if (status_i.scan_end) state_d = StDone;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      StIdle: begin
        busy_o       = 1'b0;
        cmd_o.latch  = start_i;
      end
      StScan: begin
        cmd_o.step   = 1'b1;
      end
      StDone: begin
        cmd_o.finish = 1'b1;
      end
      default: busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= cmd_o.finish;
    end
  end

endmodule
